// ----- rtl/mpp_pkg.sv -----
// Shared types and codes for the MQTT packet parser.
`default_nettype none
package mpp_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_RETAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;

    localparam logic [3:0] TYPE_CONNACK = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;

    localparam logic [3:0] KIND_TYPE = 4'd0;
    localparam logic [3:0] KIND_LENGTH = 4'd1;
    localparam logic [3:0] KIND_ACK_FLAGS = 4'd2;
    localparam logic [3:0] KIND_ACK_CODE = 4'd3;
    localparam logic [3:0] KIND_TOPIC_LEN = 4'd4;
    localparam logic [3:0] KIND_TOPIC = 4'd5;
    localparam logic [3:0] KIND_PKT_ID = 4'd6;
    localparam logic [3:0] KIND_PAYLOAD = 4'd7;
    localparam logic [3:0] KIND_SKIPPED = 4'd8;
    localparam logic [3:0] KIND_DISCARD = 4'd9;

    localparam logic [3:0] ERR_NONE = 4'd0;
    localparam logic [3:0] ERR_LENGTH = 4'd1;
    localparam logic [3:0] ERR_ACK_SIZE = 4'd2;
    localparam logic [3:0] ERR_ACK_CODE = 4'd3;
    localparam logic [3:0] ERR_SHORT = 4'd4;
    localparam logic [3:0] ERR_RETAIN = 4'd5;
    localparam logic [3:0] ERR_TOPIC = 4'd6;
    localparam logic [3:0] ERR_DUP = 4'd7;
    localparam logic [3:0] ERR_QOS = 4'd8;
    localparam logic [3:0] ERR_NO_ID = 4'd9;
    localparam logic [3:0] ERR_ID_ZERO = 4'd10;
    localparam logic [3:0] ERR_WILDCARD = 4'd11;

    localparam logic [7:0] CHAR_PLUS = 8'h2b;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] MAX_ACK_CODE = 8'd5;

    typedef struct packed {
        logic       reject_retain;
        logic [2:0] max_length_bytes;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [3:0]  byte_kind;
        logic [3:0]  packet_type;
        logic [1:0]  qos_level;
        logic        dup_flag;
        logic [15:0] topic_length;
        logic [15:0] packet_ident;
        logic [27:0] remaining_length;
        logic        session_present;
        logic [7:0]  return_code;
        logic        packet_end;
        logic [3:0]  error_code;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/mpp_parse_core.sv -----
// Parser state and per-byte classification logic.
`default_nettype none
module mpp_parse_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_restart,
    input  wire mpp_pkg::t_cfg   i_cfg,
    output mpp_pkg::t_result     o_result
);
    import mpp_pkg::*;

    typedef enum logic [12:0] {
        PH_TYPE  = 13'b0000000000001,
        PH_LEN   = 13'b0000000000010,
        PH_ACKF  = 13'b0000000000100,
        PH_ACKC  = 13'b0000000001000,
        PH_TLH   = 13'b0000000010000,
        PH_TLL   = 13'b0000000100000,
        PH_TOPIC = 13'b0000001000000,
        PH_IDH   = 13'b0000010000000,
        PH_IDL   = 13'b0000100000000,
        PH_PAY   = 13'b0001000000000,
        PH_SKIP  = 13'b0010000000000,
        PH_DROP  = 13'b0100000000000,
        PH_DEAD  = 13'b1000000000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [27:0] r_len_acc, n_len_acc;
    logic [2:0]  r_len_cnt, n_len_cnt;
    logic [27:0] r_left, n_left;
    logic [15:0] r_topic_len, n_topic_len;
    logic [15:0] r_topic_cnt, n_topic_cnt;
    logic [15:0] r_ident, n_ident;
    logic        r_sess, n_sess;
    logic [7:0]  r_ret_code, n_ret_code;
    logic [3:0]  r_err, n_err;

    logic [3:0]  kind;
    logic        pkt_end;
    logic [2:0]  lim;
    logic [27:0] len_group;
    logic [15:0] tl_word;
    logic [15:0] id_word;
    logic [15:0] topic_cnt_inc;
    logic [1:0]  qos;
    logic        is_pub;

    assign lim = (i_cfg.max_length_bytes == 3'd0) ? 3'd1 :
                 (i_cfg.max_length_bytes > 3'd4) ? 3'd4 : i_cfg.max_length_bytes;
    assign tl_word = {r_topic_len[15:8], i_byte};
    assign id_word = {r_ident[15:8], i_byte};
    assign topic_cnt_inc = r_topic_cnt + 16'd1;
    assign qos = r_type[2:1];

    // place the seven payload bits of a length byte at its group position
    always_comb begin
        case (r_len_cnt[1:0])
            2'd0: len_group = {21'd0, i_byte[6:0]};
            2'd1: len_group = {14'd0, i_byte[6:0], 7'd0};
            2'd2: len_group = {7'd0, i_byte[6:0], 14'd0};
            default: len_group = {i_byte[6:0], 21'd0};
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_type = r_type;
        n_len_acc = r_len_acc;
        n_len_cnt = r_len_cnt;
        n_left = r_left;
        n_topic_len = r_topic_len;
        n_topic_cnt = r_topic_cnt;
        n_ident = r_ident;
        n_sess = r_sess;
        n_ret_code = r_ret_code;
        n_err = r_err;
        kind = KIND_DISCARD;
        pkt_end = 1'b0;

        if (i_restart || r_phase == PH_TYPE) begin
            n_type = i_byte;
            n_len_acc = '0;
            n_len_cnt = '0;
            n_left = '0;
            n_topic_len = '0;
            n_topic_cnt = '0;
            n_ident = '0;
            n_sess = 1'b0;
            n_ret_code = '0;
            n_err = ERR_NONE;
            n_phase = PH_LEN;
            kind = KIND_TYPE;
        end else if (r_phase == PH_LEN) begin
            kind = KIND_LENGTH;
            n_len_acc = r_len_acc | len_group;
            n_len_cnt = r_len_cnt + 3'd1;
            if (i_byte[7]) begin
                if (n_len_cnt >= lim) begin
                    n_err = ERR_LENGTH;
                    n_phase = PH_DEAD;
                end
            end else begin
                n_left = n_len_acc;
                if (r_type[7:4] == TYPE_CONNACK) begin
                    if (n_len_acc != 28'd2) n_err = ERR_ACK_SIZE;
                    n_phase = PH_ACKF;
                end else if (r_type[7:4] == TYPE_PUBLISH) begin
                    if (n_len_acc < 28'd2) n_err = ERR_SHORT;
                    else if (r_type[0] && i_cfg.reject_retain) n_err = ERR_RETAIN;
                    n_phase = PH_TLH;
                end else begin
                    n_phase = PH_SKIP;
                end
                if (n_left == 28'd0) begin
                    pkt_end = 1'b1;
                    n_phase = PH_TYPE;
                end else if (n_err != ERR_NONE) begin
                    n_phase = PH_DROP;
                end
            end
        end else if (r_phase == PH_DEAD) begin
            kind = KIND_DISCARD;
        end else begin
            n_left = r_left - 28'd1;
            case (r_phase)
                PH_ACKF: begin
                    kind = KIND_ACK_FLAGS;
                    n_sess = i_byte[0];
                    n_phase = PH_ACKC;
                end
                PH_ACKC: begin
                    kind = KIND_ACK_CODE;
                    n_ret_code = i_byte;
                    if ((r_sess && i_byte != 8'd0) || i_byte > MAX_ACK_CODE) begin
                        n_err = ERR_ACK_CODE;
                    end
                    n_phase = PH_PAY;
                end
                PH_TLH: begin
                    kind = KIND_TOPIC_LEN;
                    n_topic_len = {i_byte, 8'd0};
                    n_phase = PH_TLL;
                end
                PH_TLL: begin
                    kind = KIND_TOPIC_LEN;
                    n_topic_len = tl_word;
                    if (({12'd0, tl_word} + 28'd2) > r_len_acc) n_err = ERR_TOPIC;
                    else if (qos == 2'd0 && r_type[3]) n_err = ERR_DUP;
                    else if (qos == 2'd3) n_err = ERR_QOS;
                    else if (qos != 2'd0 && ({12'd0, tl_word} + 28'd4) > r_len_acc) begin
                        n_err = ERR_NO_ID;
                    end
                    if (tl_word != 16'd0) n_phase = PH_TOPIC;
                    else n_phase = (qos != 2'd0) ? PH_IDH : PH_PAY;
                end
                PH_TOPIC: begin
                    kind = KIND_TOPIC;
                    n_topic_cnt = topic_cnt_inc;
                    if (i_byte inside {CHAR_PLUS, CHAR_HASH}) n_err = ERR_WILDCARD;
                    if (topic_cnt_inc >= r_topic_len) begin
                        n_phase = (qos != 2'd0) ? PH_IDH : PH_PAY;
                    end
                end
                PH_IDH: begin
                    kind = KIND_PKT_ID;
                    n_ident = {i_byte, 8'd0};
                    n_phase = PH_IDL;
                end
                PH_IDL: begin
                    kind = KIND_PKT_ID;
                    n_ident = id_word;
                    if (id_word == 16'd0) n_err = ERR_ID_ZERO;
                    n_phase = PH_PAY;
                end
                PH_PAY: kind = KIND_PAYLOAD;
                PH_SKIP: kind = KIND_SKIPPED;
                default: kind = KIND_DISCARD;
            endcase
            if (n_left == 28'd0) begin
                pkt_end = 1'b1;
                n_phase = PH_TYPE;
            end else if (n_err != ERR_NONE) begin
                n_phase = PH_DROP;
            end
        end
    end

    assign is_pub = (n_type[7:4] == TYPE_PUBLISH);

    always_comb begin
        o_result.byte_out = i_byte;
        o_result.byte_kind = kind;
        o_result.packet_type = n_type[7:4];
        o_result.qos_level = is_pub ? n_type[2:1] : 2'd0;
        o_result.dup_flag = is_pub ? n_type[3] : 1'b0;
        o_result.topic_length = n_topic_len;
        o_result.packet_ident = n_ident;
        o_result.remaining_length = n_len_acc;
        o_result.session_present = n_sess;
        o_result.return_code = n_ret_code;
        o_result.packet_end = pkt_end;
        o_result.error_code = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_type <= '0;
            r_len_acc <= '0;
            r_len_cnt <= '0;
            r_left <= '0;
            r_topic_len <= '0;
            r_topic_cnt <= '0;
            r_ident <= '0;
            r_sess <= 1'b0;
            r_ret_code <= '0;
            r_err <= ERR_NONE;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_type <= n_type;
            r_len_acc <= n_len_acc;
            r_len_cnt <= n_len_cnt;
            r_left <= n_left;
            r_topic_len <= n_topic_len;
            r_topic_cnt <= n_topic_cnt;
            r_ident <= n_ident;
            r_sess <= n_sess;
            r_ret_code <= n_ret_code;
            r_err <= n_err;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mpp_out_skid.sv -----
// Result register with a skid stage between the parser and the output channel.
`default_nettype none
module mpp_out_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire mpp_pkg::t_result  i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output mpp_pkg::t_result       o_data
);
    import mpp_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    in_xfer;
    logic    out_xfer;

    assign o_stall = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data = r_main;
    assign in_xfer = i_valid && !r_skid_valid;
    assign out_xfer = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain the skid entry into the output register
            if (out_xfer) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (r_main_valid && !out_xfer) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xfer) r_main <= r_skid;
        end else if (in_xfer) begin
            if (r_main_valid && !out_xfer) r_skid <= i_data;
            else r_main <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mqtt_packet_parser_top.sv -----
// Top level of the MQTT 3.1.1 receive packet parser.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_byte_in, i_restart
//   out     | output    | o_out_valid / i_out_stall  | o_byte_out .. o_error_code
//   cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One byte per clock while o_in_stall is low: each accepted byte is classified by
// the parse core in the cycle it is taken, and its result is registered into the
// output register, or into the skid register while the output is stalled. The skid
// stage lets one more byte in while a result is stalled; o_in_stall rises only when
// both result slots are full. Synchronous active-low reset returns the parser to
// expecting a type byte and sets reject_retain to 1 and max_length_bytes to 4.
`default_nettype none
module mqtt_packet_parser_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [7:0]                      i_byte_in,
    input  wire logic                            i_restart,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [7:0]                           o_byte_out,
    output logic [3:0]                           o_byte_kind,
    output logic [3:0]                           o_packet_type,
    output logic [1:0]                           o_qos_level,
    output logic                                 o_dup_flag,
    output logic [15:0]                          o_topic_length,
    output logic [15:0]                          o_packet_ident,
    output logic [27:0]                          o_remaining_length,
    output logic                                 o_session_present,
    output logic [7:0]                           o_return_code,
    output logic                                 o_packet_end,
    output logic [3:0]                           o_error_code,
    input  wire logic                            i_cfg_we,
    input  wire logic [mpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mpp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mpp_pkg::*;

    t_cfg    r_cfg;
    t_result core_result;
    t_result out_result;
    logic    core_stall;
    logic    in_xfer;

    assign in_xfer = i_in_valid && !core_stall;
    assign o_in_stall = core_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reject_retain <= 1'b1;
            r_cfg.max_length_bytes <= 3'd4;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_REJECT_RETAIN) begin
                r_cfg.reject_retain <= i_cfg_data[0];
            end else if (i_cfg_idx == CFG_MAX_LENGTH) begin
                r_cfg.max_length_bytes <= i_cfg_data[2:0];
            end
        end
    end

    mpp_parse_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_xfer),
        .i_byte    (i_byte_in),
        .i_restart (i_restart),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    mpp_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (core_stall),
        .i_data  (core_result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_result)
    );

    assign o_byte_out = out_result.byte_out;
    assign o_byte_kind = out_result.byte_kind;
    assign o_packet_type = out_result.packet_type;
    assign o_qos_level = out_result.qos_level;
    assign o_dup_flag = out_result.dup_flag;
    assign o_topic_length = out_result.topic_length;
    assign o_packet_ident = out_result.packet_ident;
    assign o_remaining_length = out_result.remaining_length;
    assign o_session_present = out_result.session_present;
    assign o_return_code = out_result.return_code;
    assign o_packet_end = out_result.packet_end;
    assign o_error_code = out_result.error_code;

endmodule
`default_nettype wire

// ----- rtl/mpp_checker.sv -----
// Port-level assertions for the MQTT packet parser, bound to the top level.
`default_nettype none
module mpp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_byte_out,
    input wire logic [3:0]  o_byte_kind,
    input wire logic [3:0]  o_packet_type,
    input wire logic [27:0] o_remaining_length,
    input wire logic        o_packet_end,
    input wire logic [3:0]  o_error_code
);
    import mpp_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_out)
            && $stable(o_byte_kind))
        else $error("stalled result changed");

    // a type byte opens a clean packet
    a_type_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_kind == KIND_TYPE |->
            o_error_code == ERR_NONE && o_remaining_length == 28'd0 && !o_packet_end)
        else $error("type byte carries stale packet state");

    // topic and packet id bytes only occur inside a PUBLISH
    a_pub_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_byte_kind == KIND_TOPIC || o_byte_kind == KIND_PKT_ID
            || o_byte_kind == KIND_TOPIC_LEN) |-> o_packet_type == TYPE_PUBLISH)
        else $error("publish field outside a PUBLISH packet");

    // a length error never ends a packet
    a_len_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code == ERR_LENGTH |-> !o_packet_end)
        else $error("packet end after a length error");

endmodule

bind mqtt_packet_parser_top mpp_checker u_mpp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_byte_out         (o_byte_out),
    .o_byte_kind        (o_byte_kind),
    .o_packet_type      (o_packet_type),
    .o_remaining_length (o_remaining_length),
    .o_packet_end       (o_packet_end),
    .o_error_code       (o_error_code)
);
`default_nettype wire
